>>> design/dbcm_pkg.sv
package dbcm_pkg;

  localparam int unsigned DivisorWidth = 32;
  localparam logic [31:0] DivisorMask  = 32'((64'd1 << DivisorWidth) - 64'd1);
  localparam logic [63:0] AllOnes      = 64'hffff_ffff_ffff_ffff;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_STRIP,
    ST_DIV_J,
    ST_DIV_LO,
    ST_DIV_K,
    ST_LOAD_HI,
    ST_DIV_HI,
    ST_REDUCE,
    ST_DIV_NEAR,
    ST_ROUND,
    ST_TRIM,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    DIV_NONE,
    DIV_J,
    DIV_LO,
    DIV_K,
    DIV_HI,
    DIV_NEAR
  } div_sel_t;

  typedef struct packed {
    logic     load;
    logic     strip;
    logic     div_start;
    div_sel_t div_sel;
    logic     div_step;
    div_sel_t div_save;
    logic     reduce;
    logic     pick;
    logic     round_up;
    logic     trim;
    logic     pow2;
    logic     finish;
  } cmd_t;

  typedef struct packed {
    logic is_zero;
    logic t_even;
    logic t_one;
    logic div_done;
    logic reduce_more;
    logic hi_fits;
    logic trim_more;
  } status_t;

endpackage

>>> design/dbcm_if.sv
interface dbcm_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] divisor;
  modport source (output valid, output divisor, input ready);
  modport sink (input valid, input divisor, output ready);
endinterface

interface dbcm_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] multiplier;
  logic [63:0] addend;
  logic [5:0]  shift;
  logic        zero_divisor;
  modport source (output valid, output multiplier, output addend, output shift,
                  output zero_divisor, input ready);
  modport sink (input valid, input multiplier, input addend, input shift,
                input zero_divisor, output ready);
endinterface

>>> design/dbcm_ctrl.sv
module dbcm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  dbcm_pkg::status_t sts,
  output dbcm_pkg::cmd_t    cmd
);

  dbcm_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dbcm_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == dbcm_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dbcm_pkg::ST_IDLE: if (in_valid) state_nxt = dbcm_pkg::ST_STRIP;
      dbcm_pkg::ST_STRIP: begin
        if (sts.is_zero) state_nxt = dbcm_pkg::ST_DONE;
        else if (!sts.t_even) begin
          if (sts.t_one) state_nxt = dbcm_pkg::ST_DONE;
          else state_nxt = dbcm_pkg::ST_DIV_J;
        end
      end
      dbcm_pkg::ST_DIV_J: if (sts.div_done) state_nxt = dbcm_pkg::ST_DIV_LO;
      dbcm_pkg::ST_DIV_LO: if (sts.div_done) state_nxt = dbcm_pkg::ST_DIV_K;
      dbcm_pkg::ST_DIV_K: if (sts.div_done) state_nxt = dbcm_pkg::ST_LOAD_HI;
      dbcm_pkg::ST_LOAD_HI: state_nxt = dbcm_pkg::ST_DIV_HI;
      dbcm_pkg::ST_DIV_HI: if (sts.div_done) state_nxt = dbcm_pkg::ST_REDUCE;
      dbcm_pkg::ST_REDUCE: begin
        if (!sts.reduce_more) begin
          if (sts.hi_fits) state_nxt = dbcm_pkg::ST_TRIM;
          else state_nxt = dbcm_pkg::ST_DIV_NEAR;
        end
      end
      dbcm_pkg::ST_DIV_NEAR: if (sts.div_done) state_nxt = dbcm_pkg::ST_ROUND;
      dbcm_pkg::ST_ROUND: state_nxt = dbcm_pkg::ST_TRIM;
      dbcm_pkg::ST_TRIM: if (!sts.trim_more) state_nxt = dbcm_pkg::ST_DONE;
      dbcm_pkg::ST_DONE: if (!out_valid_r || out_ready) state_nxt = dbcm_pkg::ST_IDLE;
      default: state_nxt = dbcm_pkg::ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd           = '0;
    cmd.div_sel   = dbcm_pkg::DIV_NONE;
    cmd.div_save  = dbcm_pkg::DIV_NONE;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      dbcm_pkg::ST_IDLE: cmd.load = in_valid;
      dbcm_pkg::ST_STRIP: begin
        if (!sts.is_zero && sts.t_even) cmd.strip = 1'b1;
        if (!sts.is_zero && !sts.t_even && sts.t_one) cmd.pow2 = 1'b1;
        if (!sts.is_zero && !sts.t_even && !sts.t_one) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = dbcm_pkg::DIV_J;
        end
      end
      dbcm_pkg::ST_DIV_J: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          cmd.div_save  = dbcm_pkg::DIV_J;
          cmd.div_start = 1'b1;
          cmd.div_sel   = dbcm_pkg::DIV_LO;
        end
      end
      dbcm_pkg::ST_DIV_LO: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          cmd.div_save  = dbcm_pkg::DIV_LO;
          cmd.div_start = 1'b1;
          cmd.div_sel   = dbcm_pkg::DIV_K;
        end
      end
      dbcm_pkg::ST_DIV_K: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) cmd.div_save = dbcm_pkg::DIV_K;
      end
      dbcm_pkg::ST_LOAD_HI: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = dbcm_pkg::DIV_HI;
      end
      dbcm_pkg::ST_DIV_HI: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) cmd.div_save = dbcm_pkg::DIV_HI;
      end
      dbcm_pkg::ST_REDUCE: begin
        if (sts.reduce_more) cmd.reduce = 1'b1;
        else if (sts.hi_fits) cmd.pick = 1'b1;
        else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = dbcm_pkg::DIV_NEAR;
        end
      end
      dbcm_pkg::ST_DIV_NEAR: cmd.div_step = 1'b1;
      dbcm_pkg::ST_ROUND: cmd.round_up = 1'b1;
      dbcm_pkg::ST_TRIM: begin
        if (sts.trim_more) cmd.trim = 1'b1;
      end
      dbcm_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> design/dbcm_dp.sv
module dbcm_dp (
  input  logic              clk,
  input  dbcm_pkg::cmd_t    cmd,
  input  logic [31:0]       in_divisor,
  output dbcm_pkg::status_t sts,
  output logic [63:0]       out_multiplier,
  output logic [63:0]       out_addend,
  output logic [5:0]        out_shift,
  output logic              out_zero_divisor
);

  logic [31:0]  t_r, t_nxt;
  logic [5:0]   n_r, n_nxt;
  logic [6:0]   l_r, l_nxt;
  logic [31:0]  j_r, j_nxt;
  logic [127:0] k_r, k_nxt;
  logic [127:0] lob_r, lob_nxt;
  logic [127:0] hib_r, hib_nxt;
  logic [63:0]  m_r, m_nxt;
  logic [63:0]  a_r, a_nxt;
  logic [6:0]   s_r, s_nxt;
  logic         zero_r, zero_nxt;
  logic [63:0]  om_r, om_nxt;
  logic [63:0]  oa_r, oa_nxt;
  logic [5:0]   os_r, os_nxt;
  logic         oz_r, oz_nxt;

  // shared restoring divider: 128 / 64, one bit per cycle
  logic [127:0] num_r, num_nxt;
  logic [127:0] q_r, q_nxt;
  logic [63:0]  d_r, d_nxt;
  logic [63:0]  rem_r, rem_nxt;
  logic [6:0]   cnt_r, cnt_nxt;
  logic [4:0]   lg;
  logic [127:0] pnum;
  logic [64:0]  rsh;
  logic [64:0]  rdiff;
  logic         qbit;
  logic [127:0] qfin;
  logic [63:0]  rfin;
  logic [63:0]  rounded;
  logic [31:0]  masked;

  always_comb begin
    lg = '0;
    for (int i = 1; i < 32; i++) begin
      if (t_r[i]) lg = 5'(i);
    end
  end
  assign masked  = in_divisor & dbcm_pkg::DivisorMask;
  assign pnum    = 128'd1 << (7'd64 + l_r);
  assign rsh     = {rem_r, num_r[127]};
  assign rdiff   = rsh - {1'b0, d_r};
  assign qbit    = rsh[64] || !rdiff[64];
  assign qfin    = {q_r[126:0], qbit};
  assign rfin    = qbit ? rdiff[63:0] : rsh[63:0];
  assign rounded = q_r[63:0] + ((rem_r > {33'd0, t_r[31:1]}) ? 64'd1 : 64'd0);

  assign sts.is_zero     = zero_r;
  assign sts.t_even      = !t_r[0];
  assign sts.t_one       = (t_r == 32'd1);
  assign sts.div_done    = (cnt_r == 7'd127);
  assign sts.reduce_more = ((lob_r >> 1) < (hib_r >> 1)) && (l_r != '0);
  assign sts.hi_fits     = (hib_r[127:64] == '0);
  assign sts.trim_more   = (m_r != '0) && !m_r[0] && (s_r != '0);

  always_ff @(posedge clk) begin
    t_r <= t_nxt; n_r <= n_nxt; l_r <= l_nxt; j_r <= j_nxt;
    k_r <= k_nxt; lob_r <= lob_nxt; hib_r <= hib_nxt;
    m_r <= m_nxt; a_r <= a_nxt; s_r <= s_nxt; zero_r <= zero_nxt;
    om_r <= om_nxt; oa_r <= oa_nxt; os_r <= os_nxt; oz_r <= oz_nxt;
    num_r <= num_nxt; q_r <= q_nxt; d_r <= d_nxt; rem_r <= rem_nxt; cnt_r <= cnt_nxt;
  end

  always_comb begin
    t_nxt = t_r; n_nxt = n_r; l_nxt = l_r; j_nxt = j_r;
    k_nxt = k_r; lob_nxt = lob_r; hib_nxt = hib_r;
    m_nxt = m_r; a_nxt = a_r; s_nxt = s_r; zero_nxt = zero_r;
    om_nxt = om_r; oa_nxt = oa_r; os_nxt = os_r; oz_nxt = oz_r;
    num_nxt = num_r; q_nxt = q_r; d_nxt = d_r; rem_nxt = rem_r; cnt_nxt = cnt_r;

    if (cmd.load) begin
      t_nxt    = masked;
      n_nxt    = '0;
      zero_nxt = (masked == '0);
    end
    if (cmd.strip) begin
      t_nxt = t_r >> 1;
      n_nxt = n_r + 6'd1;
    end
    if (cmd.pow2) begin
      m_nxt = '1; a_nxt = '1; s_nxt = '0;
    end
    if (cmd.div_step) begin
      rem_nxt = rfin;
      q_nxt   = qfin;
      num_nxt = {num_r[126:0], 1'b0};
      cnt_nxt = cnt_r + 7'd1;
    end
    // store the result of the division that ends this cycle
    unique case (cmd.div_save)
      dbcm_pkg::DIV_J:  j_nxt   = rfin[31:0];
      dbcm_pkg::DIV_LO: lob_nxt = qfin;
      dbcm_pkg::DIV_K:  k_nxt   = qfin;
      dbcm_pkg::DIV_HI: hib_nxt = qfin;
      default: ;
    endcase
    if (cmd.div_start) begin
      cnt_nxt = '0;
      q_nxt   = '0;
      rem_nxt = '0;
      unique case (cmd.div_sel)
        dbcm_pkg::DIV_J: begin
          // all ones mod t
          l_nxt   = {2'd0, lg} + 7'd1;
          num_nxt = {64'd0, dbcm_pkg::AllOnes};
          d_nxt   = {32'd0, t_r};
        end
        dbcm_pkg::DIV_LO: begin
          num_nxt = pnum;
          d_nxt   = {32'd0, t_r};
        end
        dbcm_pkg::DIV_K: begin
          num_nxt = pnum;
          d_nxt   = dbcm_pkg::AllOnes - {32'd0, j_r};
        end
        dbcm_pkg::DIV_HI: begin
          num_nxt = pnum + k_r;
          d_nxt   = {32'd0, t_r};
        end
        dbcm_pkg::DIV_NEAR: begin
          s_nxt   = {2'd0, lg};
          num_nxt = 128'd1 << (7'd64 + {2'd0, lg});
          d_nxt   = {32'd0, t_r};
        end
        default: ;
      endcase
    end
    if (cmd.reduce) begin
      lob_nxt = lob_r >> 1;
      hib_nxt = hib_r >> 1;
      l_nxt   = l_r - 7'd1;
    end
    if (cmd.pick) begin
      m_nxt = hib_r[63:0];
      a_nxt = '0;
      s_nxt = l_r;
    end
    if (cmd.round_up) begin
      m_nxt = rounded;
      a_nxt = rounded;
    end
    if (cmd.trim) begin
      m_nxt = m_r >> 1;
      a_nxt = a_r >> 1;
      s_nxt = s_r - 7'd1;
    end
    if (cmd.finish) begin
      oz_nxt = zero_r;
      if (zero_r) begin
        om_nxt = '0; oa_nxt = '0; os_nxt = '0;
      end else begin
        om_nxt = m_r; oa_nxt = a_r; os_nxt = 6'(s_r + {1'b0, n_r});
      end
    end
  end

  assign out_multiplier   = om_r;
  assign out_addend       = oa_r;
  assign out_shift        = os_r;
  assign out_zero_divisor = oz_r;

endmodule

>>> design/div_by_constant_magic_gen_top.sv
// divisor magic-value generator
// in channel: one divisor per transaction; out channel: multiplier, addend,
// shift and zero_divisor per transaction, one result for every divisor
// processing from accept to result: the trailing zeros of the divisor are stripped
// one at a time, then four bit-serial divisions (128 / 64 restoring divider, one
// quotient bit per cycle) run with a set-up state before the last, then the
// reduction steps, a fifth division plus a rounding step when the high bound
// does not fit 64 bits, and the trim steps
// a zero divisor goes straight from the strip state to the result, and a power
// of two does so once its trailing zeros are stripped; the block returns to idle
// before the next divisor is taken
// one divisor is worked on at a time: in_ready is high only when idle
// the result sits in an output register until out_ready takes it; a new
// divisor is accepted while that result still waits, and its own result
// then holds the block until the register is free
// reset clears the controller and drops out_valid; no clearing pass
module div_by_constant_magic_gen_top (
  input  logic clk,
  input  logic rst_n,
  dbcm_in_if.sink    in_ch,
  dbcm_out_if.source out_ch
);

  dbcm_pkg::cmd_t    cmd;
  dbcm_pkg::status_t sts;

  dbcm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dbcm_dp u_dp (
    .clk              (clk),
    .cmd              (cmd),
    .in_divisor       (in_ch.divisor),
    .sts              (sts),
    .out_multiplier   (out_ch.multiplier),
    .out_addend       (out_ch.addend),
    .out_shift        (out_ch.shift),
    .out_zero_divisor (out_ch.zero_divisor)
  );

endmodule

>>> test/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] AllOnes = 64'hffff_ffff_ffff_ffff;
  localparam int unsigned RandomCount = 820;

  typedef struct packed {
    logic [63:0] multiplier;
    logic [63:0] addend;
    logic [5:0]  shift;
    logic        zero_divisor;
  } magic_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  dbcm_in_if  in_ch ();
  dbcm_out_if out_ch ();

  div_by_constant_magic_gen_top u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  magic_t      pending_magic_q[$];
  int unsigned error_count = 0;
  int unsigned checked_count = 0;
  int unsigned zero_count = 0;
  int unsigned pow2_count = 0;
  int unsigned burst_left = 1;
  logic        hold_toggle = 1'b0;

  function automatic int unsigned msb_index(input logic [63:0] v);
    int unsigned idx;
    idx = 0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) idx = i;
    end
    return idx;
  endfunction

  function automatic magic_t magic_for_divisor(input logic [31:0] divisor);
    magic_t       res;
    logic [63:0]  odd_part;
    logic [63:0]  rem_j;
    logic [127:0] pow_l;
    logic [127:0] k_val;
    logic [127:0] low_bound;
    logic [127:0] high_bound;
    logic [127:0] near_q;
    logic [127:0] near_r;
    logic [63:0]  mult;
    logic [63:0]  add;
    int unsigned  zeros;
    int unsigned  l_exp;
    int unsigned  sh;
    res = '0;
    zeros = 0;
    odd_part = {32'd0, divisor & dbcm_pkg::DivisorMask};
    if (odd_part == 64'd0) begin
      res.zero_divisor = 1'b1;
      return res;
    end
    while (!odd_part[0]) begin
      odd_part = odd_part >> 1;
      zeros++;
    end
    if (odd_part == 64'd1) begin
      mult = AllOnes;
      add = AllOnes;
      sh = 0;
    end else begin
      l_exp = msb_index(odd_part) + 1;
      rem_j = AllOnes % odd_part;
      pow_l = 128'd1 << (64 + l_exp);
      k_val = pow_l / {64'd0, AllOnes - rem_j};
      low_bound = pow_l / {64'd0, odd_part};
      high_bound = (pow_l + k_val) / {64'd0, odd_part};
      while ((low_bound >> 1) < (high_bound >> 1) && l_exp > 0) begin
        low_bound = low_bound >> 1;
        high_bound = high_bound >> 1;
        l_exp--;
      end
      if (high_bound[127:64] == 64'd0) begin
        mult = high_bound[63:0];
        sh = l_exp;
        add = 64'd0;
      end else begin
        sh = msb_index(odd_part);
        near_q = (128'd1 << (64 + sh)) / {64'd0, odd_part};
        near_r = (128'd1 << (64 + sh)) % {64'd0, odd_part};
        if (near_r[63:0] > (odd_part >> 1)) near_q = near_q + 128'd1;
        mult = near_q[63:0];
        add = mult;
      end
      while (mult != 64'd0 && !mult[0] && sh > 0) begin
        mult = mult >> 1;
        add = add >> 1;
        sh--;
      end
    end
    sh = sh + zeros;
    res.multiplier = mult;
    res.addend = add;
    res.shift = sh[5:0];
    return res;
  endfunction

  // sender: one divisor per transaction, bursts with random gaps
  task automatic send_divisor(input logic [31:0] divisor);
    int unsigned gap;
    in_ch.valid <= 1'b1;
    in_ch.divisor <= divisor;
    do @(posedge clk); while (!in_ch.ready);
    pending_magic_q.push_back(magic_for_divisor(divisor));
    burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_magic_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic logic [31:0] random_divisor();
    logic [31:0] d;
    int unsigned sel;
    sel = $urandom_range(0, 39);
    if (sel == 0) d = 32'd0;
    else if (sel < 4) d = 32'd1 << $urandom_range(0, 31);
    else if (sel < 14) d = $urandom_range(3, 1000);
    else if (sel < 22) d = $urandom >> $urandom_range(1, 30);
    else if (sel < 28) d = ($urandom | 32'd1) << $urandom_range(1, 31);
    else d = $urandom;
    return d;
  endfunction

  task automatic test_directed();
    logic [31:0] list [21];
    list = '{32'd0, 32'd1, 32'd2, 32'h8000_0000, 32'd3, 32'd5, 32'd6, 32'd7, 32'd10,
             32'd641, 32'd12345, 32'h7fff_ffff, 32'hffff_ffff, 32'hffff_fffe,
             32'h5555_5555, 32'haaaa_aaaa, 32'h0001_0001, 32'h8000_0001,
             32'hc000_0000, 32'd25, 32'd1000};
    foreach (list[i]) send_divisor(list[i]);
    wait_drained();
  endtask

  task automatic test_random();
    for (int i = 0; i < RandomCount; i++) begin
      send_divisor(random_divisor());
      if (i == RandomCount / 3) wait_drained();
    end
    wait_drained();
  endtask

  task automatic test_output_backpressure();
    @(posedge clk);
    hold_toggle <= ~hold_toggle;
    for (int i = 0; i < 6; i++) send_divisor(random_divisor());
    wait_drained();
  endtask

  // receiver: random stall pattern plus a long hold-off when the back-pressure test asks for one
  logic [15:0] ready_pattern;
  int unsigned pattern_age;
  int unsigned hold_left;
  logic        hold_seen;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      ready_pattern <= 16'hffff;
      pattern_age <= 0;
      hold_left <= 0;
      hold_seen <= hold_toggle;
    end else if (hold_seen != hold_toggle) begin
      hold_seen <= hold_toggle;
      hold_left <= 3000;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= (hold_left == 1);
    end else begin
      out_ch.ready <= ready_pattern[0];
      if (pattern_age == 63) begin
        pattern_age <= 0;
        ready_pattern <= ($urandom_range(0, 2) == 0) ? 16'hffff : 16'($urandom);
      end else begin
        pattern_age <= pattern_age + 1;
        ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
      end
    end
  end

  always @(posedge clk) begin
    magic_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_magic_q.size() == 0) begin
        $display("%0t: unexpected result mult=%h add=%h shift=%0d zero=%b", $time,
                 out_ch.multiplier, out_ch.addend, out_ch.shift, out_ch.zero_divisor);
        error_count++;
      end else begin
        want = pending_magic_q.pop_front();
        checked_count++;
        if (want.zero_divisor) zero_count++;
        else if (want.addend == AllOnes) pow2_count++;
        if (out_ch.multiplier !== want.multiplier) begin
          $display("%0t: multiplier expected %h actual %h", $time, want.multiplier,
                   out_ch.multiplier);
          error_count++;
        end
        if (out_ch.addend !== want.addend) begin
          $display("%0t: addend expected %h actual %h", $time, want.addend, out_ch.addend);
          error_count++;
        end
        if (out_ch.shift !== want.shift) begin
          $display("%0t: shift expected %0d actual %0d", $time, want.shift, out_ch.shift);
          error_count++;
        end
        if (out_ch.zero_divisor !== want.zero_divisor) begin
          $display("%0t: zero_divisor expected %b actual %b", $time, want.zero_divisor,
                   out_ch.zero_divisor);
          error_count++;
        end
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.divisor = 32'd0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_output_backpressure();
    test_random();
    if (pending_magic_q.size() != 0) error_count++;
    $display("covered %0d divisors: %0d zero, %0d power of two, rest general",
             checked_count, zero_count, pow2_count);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("simulation failed");
    $finish;
  end

endmodule

>>> div_by_constant_magic_gen_top.f
design/dbcm_pkg.sv
design/dbcm_if.sv
design/dbcm_ctrl.sv
design/dbcm_dp.sv
design/div_by_constant_magic_gen_top.sv
test/testbench.sv
